// ----- sv/pes_pkg.sv -----
// Package with the shared constants, payload structs and control types of product_except_self.
`default_nettype none

package pes_pkg;

    localparam int MAX_LEN   = 64;
    localparam int WIDTH     = 32;
    localparam int FIELD_W   = 32;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] element_value;
        logic                      element_last;
    } element_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] product_value;
        logic                      result_last;
        logic                      length_overflow;
    } result_t;

    typedef enum logic [1:0] {
        SEL_A_PREFIX,
        SEL_A_PARTIAL,
        SEL_A_SUFFIX
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        SEL_B_ELEMENT,
        SEL_B_SUFFIX,
        SEL_B_VALUE
    } mul_b_sel_t;

    typedef struct packed {
        logic       busy;
        logic       load;
        logic       suffix_init;
        logic       idx_top;
        logic       idx_clear;
        logic       mem_read;
        logic       partial_write;
        logic       suffix_write;
        logic       idx_dec;
        logic       idx_inc;
        logic       emit;
        logic       clear;
        mul_a_sel_t mul_a;
        mul_b_sel_t mul_b;
    } ctrl_t;

    typedef struct packed {
        logic idx_is_zero;
        logic at_end;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/pes_useq.sv -----
// Microcoded sequencer of product_except_self: step counter, control ROM and jump logic.
`default_nettype none

module pes_useq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             element_last,
    input  pes_pkg::status_t      status,
    output pes_pkg::ctrl_t        ctrl
);
    import pes_pkg::*;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_BINIT,
        STEP_BREAD,
        STEP_BMULP,
        STEP_BMULS,
        STEP_FINIT,
        STEP_FREAD,
        STEP_FEMIT,
        STEP_FDONE
    } step_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_WAIT_LAST,
        COND_IDX_NZ,
        COND_NOT_END
    } cond_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t target;
    } uword_t;

    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        w = '0;
        w.ctrl.busy   = 1'b1;
        w.ctrl.mul_a  = SEL_A_PREFIX;
        w.ctrl.mul_b  = SEL_B_ELEMENT;
        w.cond        = COND_NEXT;
        w.target      = STEP_IDLE;
        unique case (step)
            STEP_IDLE:
            begin
                w.ctrl.busy = 1'b0;
                w.ctrl.load = 1'b1;
                w.cond      = COND_WAIT_LAST;
                w.target    = STEP_IDLE;
            end
            STEP_BINIT:
            begin
                w.ctrl.suffix_init = 1'b1;
                w.ctrl.idx_top     = 1'b1;
            end
            STEP_BREAD:
            begin
                w.ctrl.mem_read = 1'b1;
            end
            STEP_BMULP:
            begin
                w.ctrl.partial_write = 1'b1;
                w.ctrl.mul_a         = SEL_A_PARTIAL;
                w.ctrl.mul_b         = SEL_B_SUFFIX;
            end
            STEP_BMULS:
            begin
                w.ctrl.suffix_write = 1'b1;
                w.ctrl.idx_dec      = 1'b1;
                w.ctrl.mul_a        = SEL_A_SUFFIX;
                w.ctrl.mul_b        = SEL_B_VALUE;
                w.cond              = COND_IDX_NZ;
                w.target            = STEP_BREAD;
            end
            STEP_FINIT:
            begin
                w.ctrl.idx_clear = 1'b1;
            end
            STEP_FREAD:
            begin
                w.ctrl.mem_read = 1'b1;
            end
            STEP_FEMIT:
            begin
                w.ctrl.emit    = 1'b1;
                w.ctrl.idx_inc = 1'b1;
                w.cond         = COND_NOT_END;
                w.target       = STEP_FREAD;
            end
            STEP_FDONE:
            begin
                w.ctrl.clear = 1'b1;
                w.cond       = COND_ALWAYS;
                w.target     = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    step_t  upc_reg;
    step_t  upc_next;
    uword_t uword;
    logic   jump;

    always_comb
    begin
        uword = ucode_rom(upc_reg);
        unique case (uword.cond)
            COND_NEXT:      jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_WAIT_LAST: jump = !(start && element_last);
            COND_IDX_NZ:    jump = !status.idx_is_zero;
            COND_NOT_END:   jump = !status.at_end;
            default:        jump = 1'b1;
        endcase
        upc_next  = jump ? uword.target : step_t'(upc_reg + 4'd1);
        ctrl      = uword.ctrl;
        ctrl.load = uword.ctrl.load && start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pes_datapath.sv -----
// Datapath of product_except_self: element and partial stores, shared multiplier, result register.
`default_nettype none

module pes_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  pes_pkg::ctrl_t        ctrl,
    input  pes_pkg::element_t     element,
    output pes_pkg::status_t      status,
    output pes_pkg::result_t      result,
    output logic                  strobe
);
    import pes_pkg::*;

    logic [WIDTH-1:0] value_mem   [MAX_LEN];
    logic [WIDTH-1:0] partial_mem [MAX_LEN];

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [WIDTH-1:0] prefix_reg;
    logic [WIDTH-1:0] prefix_next;
    logic             flag_reg;
    logic             flag_next;
    logic             strobe_reg;
    logic [WIDTH-1:0] suffix_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [WIDTH-1:0] rdv_reg;
    logic [WIDTH-1:0] rdp_reg;
    result_t          result_reg;

    logic [WIDTH-1:0] elem_ext;
    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic [WIDTH-1:0] mul_out;
    logic [CNT_W-1:0] cnt_m1;
    logic             store_ok;
    logic             store_en;
    logic [IDX_W-1:0] wr_addr;
    logic [WIDTH-1:0] partial_wdata;

    assign elem_ext = WIDTH'(element.element_value);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign store_ok = cnt_reg < CNT_W'(MAX_LEN);
    assign store_en = ctrl.load && store_ok;

    assign status.idx_is_zero = (idx_reg == '0);
    assign status.at_end      = (CNT_W'(idx_reg) == cnt_m1);

    always_comb
    begin
        case (ctrl.mul_a)
            SEL_A_PREFIX:  mul_a = prefix_reg;
            SEL_A_PARTIAL: mul_a = rdp_reg;
            SEL_A_SUFFIX:  mul_a = suffix_reg;
            default:       mul_a = prefix_reg;
        endcase
        case (ctrl.mul_b)
            SEL_B_ELEMENT: mul_b = elem_ext;
            SEL_B_SUFFIX:  mul_b = suffix_reg;
            SEL_B_VALUE:   mul_b = rdv_reg;
            default:       mul_b = elem_ext;
        endcase
        mul_out = mul_a * mul_b;
    end

    always_comb
    begin
        wr_addr       = store_en ? cnt_reg[IDX_W-1:0] : idx_reg;
        partial_wdata = store_en ? prefix_reg : mul_out;
        cnt_next      = cnt_reg;
        prefix_next   = prefix_reg;
        flag_next     = flag_reg;
        if (ctrl.clear)
        begin
            cnt_next    = '0;
            prefix_next = WIDTH'(1);
            flag_next   = 1'b0;
        end
        else if (store_en)
        begin
            cnt_next    = cnt_reg + CNT_W'(1);
            prefix_next = mul_out;
        end
        else if (ctrl.load)
        begin
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            value_mem[wr_addr] <= elem_ext;
        end
        if (store_en || ctrl.partial_write)
        begin
            partial_mem[wr_addr] <= partial_wdata;
        end
        if (ctrl.mem_read)
        begin
            rdv_reg <= value_mem[idx_reg];
            rdp_reg <= partial_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.suffix_init)
        begin
            suffix_reg <= WIDTH'(1);
        end
        else if (ctrl.suffix_write)
        begin
            suffix_reg <= mul_out;
        end
        if (ctrl.idx_top)
        begin
            idx_reg <= cnt_m1[IDX_W-1:0];
        end
        else if (ctrl.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (ctrl.idx_dec)
        begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
        else if (ctrl.idx_inc)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (ctrl.emit)
        begin
            result_reg.product_value   <= rdp_reg[FIELD_W-1:0];
            result_reg.result_last     <= status.at_end;
            result_reg.length_overflow <= flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            prefix_reg <= WIDTH'(1);
            flag_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            prefix_reg <= prefix_next;
            flag_reg   <= flag_next;
            strobe_reg <= ctrl.emit;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_LEN))
        else $error("Element count exceeds the store depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> cnt_reg != '0)
        else $error("Result emitted for an empty vector.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.result_last) |=> (cnt_reg == '0 && !flag_reg))
        else $error("Vector state not cleared after the final result.");

endmodule

`default_nettype wire

// ----- sv/product_except_self.sv -----
// Top level of product_except_self: sequencer and datapath.
//
// A request is accepted at a rising edge of clk with start high and busy low;
// element carries one vector element and its last mark. An element that is not
// last is stored and busy stays low, so elements may arrive on every
// cycle. Elements beyond 64 are dropped and flag length_overflow.
// The last element starts the microprogram: a backward pass that for each
// stored element does a memory read, prefix times suffix and a suffix update
// through the one shared 32 by 32 multiplier, then a forward pass that for
// each result does a memory read and loads the result register. Busy stays
// high after the last element until the sequencer is back in idle, and the
// results appear in index order. Each result is marked by strobe high for
// exactly one cycle; the receiver cannot stall the block. The final result
// carries result_last. Reset clears the element count, drop flag and the
// sequencer and sets the running prefix to one; the stores need no clearing
// since only written entries are read.
`default_nettype none

module product_except_self (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  pes_pkg::element_t  element,
    output pes_pkg::result_t   result,
    output logic               strobe
);
    import pes_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    pes_useq u_useq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .element_last (element.element_last),
        .status       (status),
        .ctrl         (ctrl)
    );

    pes_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .element (element),
        .status  (status),
        .result  (result),
        .strobe  (strobe)
    );

    assign busy = ctrl.busy;

endmodule

`default_nettype wire
